// ===== rtl/core/mtd_pkg.sv =====
// Shared types, codes and defaults for the multiprocessor task dispatcher.
`timescale 1ns / 1ps
`default_nettype none

package mtd_pkg;

  localparam int NUM_PROCS_DEF      = 4;
  localparam int QUEUE_DEPTH_DEF    = 128;
  localparam int MAX_TASK_SLOTS_DEF = 128;
  localparam int ID_BITS_DEF        = 16;

  localparam int OP_W       = 2;
  localparam int STATUS_W   = 3;
  localparam int SLICE_W    = 8;
  localparam int OUT_ID_W   = 16;
  localparam int OUT_PROC_W = 2;

  localparam logic [SLICE_W-1:0] SLICE_RESET = 8'd10;

  localparam logic [OP_W-1:0] OP_SUBMIT = 2'd0;
  localparam logic [OP_W-1:0] OP_GRANT  = 2'd1;
  localparam logic [OP_W-1:0] OP_REPORT = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK_PROC    = 3'd0;
  localparam logic [STATUS_W-1:0] ST_OK_WAIT    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_TABLE_FULL = 3'd2;
  localparam logic [STATUS_W-1:0] ST_IDS_OUT    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_QUEUE_FULL = 3'd4;
  localparam logic [STATUS_W-1:0] ST_NONE_READY = 3'd5;
  localparam logic [STATUS_W-1:0] ST_NO_SLICE   = 3'd6;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_RD_READY,
    S_RD_WAIT,
    S_DONE
  } state_t;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_LOAD,
    DP_SUBMIT,
    DP_GRANT_REPEAT,
    DP_GRANT_NONE,
    DP_GRANT_POP,
    DP_GRANT_TAKE,
    DP_REPORT_NONE,
    DP_REQUEUE,
    DP_RETIRE,
    DP_RETIRE_POP,
    DP_DISPATCH,
    DP_OUT
  } dp_cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            fin;
    logic            fl_valid;
    logic            ready_empty;
    logic            ready_full;
    logic            waiting_empty;
    logic            out_valid;
  } dp_stat_t;

endpackage

`default_nettype wire

// ===== rtl/core/mtd_if.sv =====
// Request and response channel interfaces of the task dispatcher.
`timescale 1ns / 1ps
`default_nettype none

interface mtd_in_if;
  import mtd_pkg::*;
  logic            valid;
  logic            ready;
  logic [OP_W-1:0] opcode;
  logic            finished;

  modport source (output valid, output opcode, output finished, input ready);
  modport sink   (input valid, input opcode, input finished, output ready);
endinterface

interface mtd_out_if;
  import mtd_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [STATUS_W-1:0]   status;
  logic [OUT_ID_W-1:0]   task_id;
  logic [OUT_PROC_W-1:0] processor;
  logic [SLICE_W-1:0]    slice_budget;
  logic                  dispatched;
  logic [OUT_ID_W-1:0]   dispatched_id;
  logic                  active;

  modport source (output valid, output status, output task_id, output processor,
                  output slice_budget, output dispatched, output dispatched_id,
                  output active, input ready);
  modport sink   (input valid, input status, input task_id, input processor,
                  input slice_budget, input dispatched, input dispatched_id,
                  input active, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/mtd_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module mtd_ram #(
  parameter  int WIDTH = 8,
  parameter  int DEPTH = 16,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/core/mtd_ctrl.sv =====
// Sequencing state machine of the task dispatcher.
`timescale 1ns / 1ps
`default_nettype none

module mtd_ctrl
  import mtd_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire logic     out_ready,
  input  wire dp_stat_t stat,
  output dp_cmd_t       cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = DP_NOP;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd        = DP_LOAD;
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        state_next = S_DONE;
        case (stat.op)
          OP_SUBMIT: cmd = DP_SUBMIT;
          OP_GRANT: begin
            if (stat.fl_valid) begin
              cmd = DP_GRANT_REPEAT;
            end else if (stat.ready_empty) begin
              cmd = DP_GRANT_NONE;
            end else begin
              cmd        = DP_GRANT_POP;
              state_next = S_RD_READY;
            end
          end
          OP_REPORT: begin
            if (!stat.fl_valid) begin
              cmd = DP_REPORT_NONE;
            end else if (!stat.fin && !stat.ready_full) begin
              cmd = DP_REQUEUE;
            end else if (stat.waiting_empty) begin
              cmd = DP_RETIRE;
            end else begin
              cmd        = DP_RETIRE_POP;
              state_next = S_RD_WAIT;
            end
          end
          default: state_next = S_IDLE;
        endcase
      end
      S_RD_READY: begin
        cmd        = DP_GRANT_TAKE;
        state_next = S_DONE;
      end
      S_RD_WAIT: begin
        cmd        = DP_DISPATCH;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (!stat.out_valid || out_ready) begin
          cmd        = DP_OUT;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/core/mtd_datapath.sv =====
// Scheduler state, ready and waiting queues, result and output registers.
`timescale 1ns / 1ps
`default_nettype none

module mtd_datapath
  import mtd_pkg::*;
#(
  parameter int NUM_PROCS      = NUM_PROCS_DEF,
  parameter int QUEUE_DEPTH    = QUEUE_DEPTH_DEF,
  parameter int MAX_TASK_SLOTS = MAX_TASK_SLOTS_DEF,
  parameter int ID_BITS        = ID_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire dp_cmd_t               cmd,
  input  wire logic [OP_W-1:0]       opcode,
  input  wire logic                  finished,
  input  wire logic                  cfg_we,
  input  wire logic [SLICE_W-1:0]    cfg_data,
  input  wire logic                  out_ready,
  output dp_stat_t                   stat,
  output logic                       out_valid,
  output logic [STATUS_W-1:0]        status,
  output logic [OUT_ID_W-1:0]        task_id,
  output logic [OUT_PROC_W-1:0]      processor,
  output logic [SLICE_W-1:0]         slice_budget,
  output logic                       dispatched,
  output logic [OUT_ID_W-1:0]        dispatched_id,
  output logic                       active
);

  localparam int PROC_W = (NUM_PROCS > 1) ? $clog2(NUM_PROCS) : 1;
  localparam int QA_W   = $clog2(QUEUE_DEPTH);
  localparam int QF_W   = $clog2(QUEUE_DEPTH + 1);
  localparam int CNT_W  = $clog2(MAX_TASK_SLOTS + 1);
  localparam int RE_W   = ID_BITS + PROC_W;

  // control state
  logic [SLICE_W-1:0]   slice_length;
  logic [ID_BITS-1:0]   next_id, next_id_next;
  logic [CNT_W-1:0]     task_total, task_total_next;
  logic [CNT_W-1:0]     active_total, active_total_next;
  logic [NUM_PROCS-1:0] busy, busy_next;
  logic [QA_W-1:0]      r_head, r_head_next, r_tail, r_tail_next;
  logic [QF_W-1:0]      r_fill, r_fill_next;
  logic [QA_W-1:0]      w_head, w_head_next, w_tail, w_tail_next;
  logic [QF_W-1:0]      w_fill, w_fill_next;
  logic                 fl_valid, fl_valid_next;
  logic                 out_valid_next;

  // payload
  logic [OP_W-1:0]      op_q;
  logic                 fin_q;
  logic [ID_BITS-1:0]   fl_id, fl_id_next;
  logic [PROC_W-1:0]    fl_proc, fl_proc_next;
  logic [STATUS_W-1:0]  res_status, res_status_next;
  logic [ID_BITS-1:0]   res_id, res_id_next;
  logic [PROC_W-1:0]    res_proc, res_proc_next;
  logic [SLICE_W-1:0]   res_budget, res_budget_next;
  logic                 res_disp, res_disp_next;
  logic [ID_BITS-1:0]   res_did, res_did_next;

  // queue memories
  logic                 r_we, w_we;
  logic [RE_W-1:0]      r_wdata, r_rdata;
  logic [ID_BITS-1:0]   w_wdata, w_rdata;

  logic                 free_found;
  logic [PROC_W-1:0]    free_idx;
  logic                 ready_full, waiting_full;
  logic [SLICE_W-1:0]   budget;
  logic [31:0]          id32, did32, proc32;

  function automatic logic [QA_W-1:0] ptr_inc(input logic [QA_W-1:0] ptr);
    return (ptr == QA_W'(QUEUE_DEPTH - 1)) ? '0 : ptr + 1'b1;
  endfunction

  function automatic logic [CNT_W-1:0] sat_dec(input logic [CNT_W-1:0] v);
    return (v == '0) ? '0 : v - 1'b1;
  endfunction

  mtd_ram #(.WIDTH(RE_W), .DEPTH(QUEUE_DEPTH)) u_ready_ram (
    .clk   (clk),
    .we    (r_we),
    .waddr (r_tail),
    .wdata (r_wdata),
    .raddr (r_head),
    .rdata (r_rdata)
  );

  mtd_ram #(.WIDTH(ID_BITS), .DEPTH(QUEUE_DEPTH)) u_waiting_ram (
    .clk   (clk),
    .we    (w_we),
    .waddr (w_tail),
    .wdata (w_wdata),
    .raddr (w_head),
    .rdata (w_rdata)
  );

  assign ready_full   = (r_fill == QF_W'(QUEUE_DEPTH));
  assign waiting_full = (w_fill == QF_W'(QUEUE_DEPTH));
  assign budget       = (slice_length == '0) ? SLICE_W'(1) : slice_length;

  assign stat.op            = op_q;
  assign stat.fin           = fin_q;
  assign stat.fl_valid      = fl_valid;
  assign stat.ready_empty   = (r_fill == '0);
  assign stat.ready_full    = ready_full;
  assign stat.waiting_empty = (w_fill == '0);
  assign stat.out_valid     = out_valid;

  // lowest-numbered free processor
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int p = NUM_PROCS - 1; p >= 0; p--) begin
      if (!busy[p]) begin
        free_found = 1'b1;
        free_idx   = PROC_W'(p);
      end
    end
  end

  always_comb begin
    next_id_next      = next_id;
    task_total_next   = task_total;
    active_total_next = active_total;
    busy_next         = busy;
    r_head_next       = r_head;
    r_tail_next       = r_tail;
    r_fill_next       = r_fill;
    w_head_next       = w_head;
    w_tail_next       = w_tail;
    w_fill_next       = w_fill;
    fl_valid_next     = fl_valid;
    fl_id_next        = fl_id;
    fl_proc_next      = fl_proc;
    res_status_next   = res_status;
    res_id_next       = res_id;
    res_proc_next     = res_proc;
    res_budget_next   = res_budget;
    res_disp_next     = res_disp;
    res_did_next      = res_did;
    r_we              = 1'b0;
    r_wdata           = {fl_id, fl_proc};
    w_we              = 1'b0;
    w_wdata           = next_id;
    out_valid_next    = out_valid && !out_ready;

    if (cmd inside {DP_SUBMIT, DP_GRANT_REPEAT, DP_GRANT_NONE, DP_GRANT_TAKE,
                    DP_REPORT_NONE, DP_REQUEUE, DP_RETIRE, DP_RETIRE_POP}) begin
      res_status_next = ST_OK_PROC;
      res_id_next     = '0;
      res_proc_next   = '0;
      res_budget_next = '0;
      res_disp_next   = 1'b0;
      res_did_next    = '0;
    end

    case (cmd)
      DP_SUBMIT: begin
        if (task_total == CNT_W'(MAX_TASK_SLOTS)) begin
          res_status_next = ST_TABLE_FULL;
        end else if (next_id == '0) begin
          res_status_next = ST_IDS_OUT;
        end else begin
          next_id_next = next_id + 1'b1;
          res_id_next  = next_id;
          if (free_found) begin
            if (ready_full) begin
              res_status_next = ST_QUEUE_FULL;
            end else begin
              r_we                = 1'b1;
              r_wdata             = {next_id, free_idx};
              r_tail_next         = ptr_inc(r_tail);
              r_fill_next         = r_fill + 1'b1;
              busy_next[free_idx] = 1'b1;
              active_total_next   = active_total + 1'b1;
              task_total_next     = task_total + 1'b1;
              res_proc_next       = free_idx;
            end
          end else if (waiting_full) begin
            res_status_next = ST_QUEUE_FULL;
          end else begin
            w_we              = 1'b1;
            w_tail_next       = ptr_inc(w_tail);
            w_fill_next       = w_fill + 1'b1;
            active_total_next = active_total + 1'b1;
            task_total_next   = task_total + 1'b1;
            res_status_next   = ST_OK_WAIT;
          end
        end
      end
      DP_GRANT_REPEAT: begin
        res_id_next     = fl_id;
        res_proc_next   = fl_proc;
        res_budget_next = budget;
      end
      DP_GRANT_NONE: res_status_next = ST_NONE_READY;
      DP_GRANT_POP: begin
        r_head_next = ptr_inc(r_head);
        r_fill_next = r_fill - 1'b1;
      end
      DP_GRANT_TAKE: begin
        fl_valid_next   = 1'b1;
        fl_id_next      = r_rdata[RE_W-1:PROC_W];
        fl_proc_next    = r_rdata[PROC_W-1:0];
        res_id_next     = r_rdata[RE_W-1:PROC_W];
        res_proc_next   = r_rdata[PROC_W-1:0];
        res_budget_next = budget;
      end
      DP_REPORT_NONE: res_status_next = ST_NO_SLICE;
      DP_REQUEUE: begin
        fl_valid_next = 1'b0;
        r_we          = 1'b1;
        r_tail_next   = ptr_inc(r_tail);
        r_fill_next   = r_fill + 1'b1;
        res_id_next   = fl_id;
        res_proc_next = fl_proc;
      end
      DP_RETIRE, DP_RETIRE_POP: begin
        fl_valid_next      = 1'b0;
        busy_next[fl_proc] = 1'b0;
        active_total_next  = sat_dec(active_total);
        res_status_next    = fin_q ? ST_OK_PROC : ST_QUEUE_FULL;
        res_id_next        = fl_id;
        res_proc_next      = fl_proc;
        if (cmd == DP_RETIRE_POP) begin
          w_head_next = ptr_inc(w_head);
          w_fill_next = w_fill - 1'b1;
        end
      end
      DP_DISPATCH: begin
        if (ready_full) begin
          active_total_next = sat_dec(active_total);
        end else begin
          r_we               = 1'b1;
          r_wdata            = {w_rdata, fl_proc};
          r_tail_next        = ptr_inc(r_tail);
          r_fill_next        = r_fill + 1'b1;
          busy_next[fl_proc] = 1'b1;
          res_disp_next      = 1'b1;
          res_did_next       = w_rdata;
        end
      end
      DP_OUT: out_valid_next = 1'b1;
      default: ;
    endcase
  end

  assign id32   = 32'(res_id);
  assign did32  = 32'(res_did);
  assign proc32 = 32'(res_proc);

  always_ff @(posedge clk) begin
    if (rst) begin
      slice_length <= SLICE_RESET;
      next_id      <= ID_BITS'(1);
      task_total   <= '0;
      active_total <= '0;
      busy         <= '0;
      r_head       <= '0;
      r_tail       <= '0;
      r_fill       <= '0;
      w_head       <= '0;
      w_tail       <= '0;
      w_fill       <= '0;
      fl_valid     <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_we) begin
        slice_length <= cfg_data;
      end
      next_id      <= next_id_next;
      task_total   <= task_total_next;
      active_total <= active_total_next;
      busy         <= busy_next;
      r_head       <= r_head_next;
      r_tail       <= r_tail_next;
      r_fill       <= r_fill_next;
      w_head       <= w_head_next;
      w_tail       <= w_tail_next;
      w_fill       <= w_fill_next;
      fl_valid     <= fl_valid_next;
      out_valid    <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd == DP_LOAD) begin
      op_q  <= opcode;
      fin_q <= finished;
    end
    fl_id      <= fl_id_next;
    fl_proc    <= fl_proc_next;
    res_status <= res_status_next;
    res_id     <= res_id_next;
    res_proc   <= res_proc_next;
    res_budget <= res_budget_next;
    res_disp   <= res_disp_next;
    res_did    <= res_did_next;
    if (cmd == DP_OUT) begin
      status        <= res_status;
      task_id       <= id32[OUT_ID_W-1:0];
      processor     <= proc32[OUT_PROC_W-1:0];
      slice_budget  <= res_budget;
      dispatched    <= res_disp;
      dispatched_id <= did32[OUT_ID_W-1:0];
      active        <= (active_total != '0);
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/multiprocessor_task_dispatcher.sv =====
// Top level of the round-robin multiprocessor task dispatcher.
//
//   channel   dir  beat contents
//   cmd       in   opcode, finished
//   rsp       out  status, task_id, processor, slice_budget, dispatched,
//                  dispatched_id, active
//   cfg_*     in   slice_length write, no read-back
//
// One command at a time: submit, repeated or empty grant, requeue, plain retire
// and a report with no open slice go from the decide state to the final state;
// a grant that pops the ready queue or a retire that pulls a waiting task first
// passes a read state, set by the registered read of the queue RAM. The final
// state loads the result; the next cmd beat is taken once the block is in idle.
// Synchronous reset leaves both queues empty with no clearing pass. A stalled
// rsp holds the result; a newer result waits in the final state until it leaves.
`timescale 1ns / 1ps
`default_nettype none

module multiprocessor_task_dispatcher
  import mtd_pkg::*;
#(
  parameter int NUM_PROCS      = NUM_PROCS_DEF,
  parameter int QUEUE_DEPTH    = QUEUE_DEPTH_DEF,
  parameter int MAX_TASK_SLOTS = MAX_TASK_SLOTS_DEF,
  parameter int ID_BITS        = ID_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  mtd_in_if.sink                  cmd,
  mtd_out_if.source               rsp,
  input  wire logic               cfg_we,
  input  wire logic [SLICE_W-1:0] cfg_data
);

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  mtd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (cmd.valid),
    .in_ready  (cmd.ready),
    .out_ready (rsp.ready),
    .stat      (dp_stat),
    .cmd       (dp_cmd)
  );

  mtd_datapath #(
    .NUM_PROCS      (NUM_PROCS),
    .QUEUE_DEPTH    (QUEUE_DEPTH),
    .MAX_TASK_SLOTS (MAX_TASK_SLOTS),
    .ID_BITS        (ID_BITS)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (dp_cmd),
    .opcode        (cmd.opcode),
    .finished      (cmd.finished),
    .cfg_we        (cfg_we),
    .cfg_data      (cfg_data),
    .out_ready     (rsp.ready),
    .stat          (dp_stat),
    .out_valid     (rsp.valid),
    .status        (rsp.status),
    .task_id       (rsp.task_id),
    .processor     (rsp.processor),
    .slice_budget  (rsp.slice_budget),
    .dispatched    (rsp.dispatched),
    .dispatched_id (rsp.dispatched_id),
    .active        (rsp.active)
  );

  // reset leaves the block idle with nothing to deliver
  a_reset_idle: assert property (@(posedge clk)
    rst |=> (cmd.ready && !rsp.valid))
    else $error("dispatcher not idle after reset");

  // an accepted command takes the controller out of idle
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (cmd.valid && cmd.ready) |=> !cmd.ready)
    else $error("second command taken while one is in work");

  // a new result is only loaded from the final controller state
  a_result_after_work: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp.valid) |-> $past(!cmd.ready))
    else $error("result appeared without a command in work");

  // a dispatch report always carries a zero slice budget
  a_dispatch_on_report: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.dispatched) |-> (rsp.slice_budget == '0))
    else $error("dispatch flagged on a grant result");

endmodule

`default_nettype wire

// ===== tb/tb_multiprocessor_task_dispatcher.sv =====
// Self-checking testbench for the multiprocessor task dispatcher.
`timescale 1ns / 1ps

module tb_multiprocessor_task_dispatcher;
  import mtd_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 600000;
  localparam int PRESSURE_HOLD = 300;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            fin;
  } cmd_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0]   status;
    logic [OUT_ID_W-1:0]   task_id;
    logic [OUT_PROC_W-1:0] processor;
    logic [SLICE_W-1:0]    slice_budget;
    logic                  dispatched;
    logic [OUT_ID_W-1:0]   dispatched_id;
    logic                  active;
  } rsp_beat_t;

  typedef struct packed {
    logic [ID_BITS_DEF-1:0] id;
    logic [OUT_PROC_W-1:0]  proc;
  } ready_slot_t;

  logic                clk = 1'b0;
  logic                rst;
  logic                cfg_we;
  logic [SLICE_W-1:0]  cfg_data;

  mtd_in_if  cmd_if ();
  mtd_out_if rsp_if ();

  multiprocessor_task_dispatcher u_dut (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd_if),
    .rsp      (rsp_if),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  // scheduler shadow state
  logic [SLICE_W-1:0]     slice_len;
  logic [ID_BITS_DEF-1:0] next_task_id;
  int                     tasks_taken;
  int                     tasks_live;
  ready_slot_t            ready_line[$];
  logic [ID_BITS_DEF-1:0] wait_line[$];
  logic [ID_BITS_DEF-1:0] proc_owner [NUM_PROCS_DEF];
  logic                   slice_open;
  logic [ID_BITS_DEF-1:0] slice_id;
  logic [OUT_PROC_W-1:0]  slice_proc;

  cmd_item_t cmd_pending[$];
  rsp_beat_t expected_rsp[$];

  int  queued_items;
  int  accepted;
  int  fail_count;
  int  cycle_count;
  int  send_gap;
  int  recv_gap;
  int  hold_cnt;
  int  next_pressure_at;
  bit  hold_rsp;
  bit  no_idle;

  always #10 clk = ~clk;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic bit predict_dispatch(input logic [OP_W-1:0] op, input logic fin,
                                          output rsp_beat_t r);
    int                     free_p;
    ready_slot_t            s;
    logic [ID_BITS_DEF-1:0] id;
    r = '0;
    if (op == OP_UNUSED) return 1'b0;
    case (op)
      OP_SUBMIT: begin
        if (tasks_taken >= MAX_TASK_SLOTS_DEF) begin
          r.status = ST_TABLE_FULL;
        end else if (next_task_id == '0) begin
          r.status = ST_IDS_OUT;
        end else begin
          id = next_task_id;
          next_task_id = next_task_id + 1'b1;
          tasks_taken++;
          r.task_id = id;
          free_p = NUM_PROCS_DEF;
          for (int i = NUM_PROCS_DEF - 1; i >= 0; i--)
            if (proc_owner[i] == '0) free_p = i;
          if (free_p < NUM_PROCS_DEF) begin
            if (ready_line.size() >= QUEUE_DEPTH_DEF) begin
              tasks_taken--;
              r.status = ST_QUEUE_FULL;
            end else begin
              s.id = id;
              s.proc = free_p[OUT_PROC_W-1:0];
              ready_line.push_back(s);
              proc_owner[free_p] = id;
              tasks_live++;
              r.status = ST_OK_PROC;
              r.processor = s.proc;
            end
          end else if (wait_line.size() >= QUEUE_DEPTH_DEF) begin
            tasks_taken--;
            r.status = ST_QUEUE_FULL;
          end else begin
            wait_line.push_back(id);
            tasks_live++;
            r.status = ST_OK_WAIT;
          end
        end
      end
      OP_GRANT: begin
        if (!slice_open && ready_line.size() == 0) begin
          r.status = ST_NONE_READY;
        end else begin
          if (!slice_open) begin
            s = ready_line.pop_front();
            slice_open = 1'b1;
            slice_id = s.id;
            slice_proc = s.proc;
          end
          r.status = ST_OK_PROC;
          r.task_id = slice_id;
          r.processor = slice_proc;
          r.slice_budget = (slice_len == '0) ? 8'd1 : slice_len;
        end
      end
      default: begin
        if (!slice_open) begin
          r.status = ST_NO_SLICE;
        end else begin
          slice_open = 1'b0;
          r.task_id = slice_id;
          r.processor = slice_proc;
          if (!fin && ready_line.size() < QUEUE_DEPTH_DEF) begin
            s.id = slice_id;
            s.proc = slice_proc;
            ready_line.push_back(s);
            r.status = ST_OK_PROC;
          end else begin
            // retire, then pull the oldest waiting task onto the freed processor
            r.status = fin ? ST_OK_PROC : ST_QUEUE_FULL;
            proc_owner[slice_proc] = '0;
            if (tasks_live > 0) tasks_live--;
            if (wait_line.size() > 0) begin
              id = wait_line.pop_front();
              if (ready_line.size() >= QUEUE_DEPTH_DEF) begin
                if (tasks_live > 0) tasks_live--;
              end else begin
                s.id = id;
                s.proc = slice_proc;
                ready_line.push_back(s);
                proc_owner[slice_proc] = id;
                r.dispatched = 1'b1;
                r.dispatched_id = id;
              end
            end
          end
        end
      end
    endcase
    r.active = (tasks_live != 0);
    return 1'b1;
  endfunction

  task automatic log_mismatch(input string msg);
    if (fail_count < 40) $display("MISMATCH @%0t: %s", $time, msg);
    fail_count++;
  endtask

  task automatic add_item(input logic [OP_W-1:0] op, input logic fin);
    cmd_item_t it;
    it.op = op;
    it.fin = fin;
    cmd_pending.push_back(it);
    if (op != OP_UNUSED) queued_items++;
  endtask

  task automatic add_random(input int n, input int submit_pct, input int fin_pct);
    int target;
    int kind;
    target = queued_items + n;
    while (queued_items < target) begin
      kind = $urandom_range(0, 99);
      if (kind < submit_pct) begin
        repeat ($urandom_range(1, 4)) add_item(OP_SUBMIT, 1'($urandom_range(0, 1)));
      end else if (kind < 88) begin
        repeat ($urandom_range(1, 3)) begin
          add_item(OP_GRANT, 1'($urandom_range(0, 1)));
          if ($urandom_range(0, 4) == 0) add_item(OP_GRANT, 1'($urandom_range(0, 1)));
          add_item(OP_REPORT, $urandom_range(0, 99) < fin_pct);
        end
      end else if (kind < 94) begin
        add_item($urandom_range(0, 1) ? OP_REPORT : OP_GRANT, 1'($urandom_range(0, 1)));
      end else begin
        add_item(OP_W'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
      end
    end
  endtask

  task automatic wait_idle(input int tail);
    while (cmd_pending.size() != 0 || cmd_if.valid || expected_rsp.size() != 0)
      @(posedge clk);
    repeat (tail) @(posedge clk);
  endtask

  task automatic write_slice(input logic [SLICE_W-1:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= v;
    slice_len = v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // command driver
  always @(posedge clk) begin : cmd_driver
    rsp_beat_t pred;
    cmd_item_t nxt;
    if (rst) begin
      cmd_if.valid <= 1'b0;
      cmd_if.opcode <= OP_SUBMIT;
      cmd_if.finished <= 1'b0;
      accepted <= 0;
      send_gap = 0;
      next_task_id = ID_BITS_DEF'(1);
      tasks_taken = 0;
      tasks_live = 0;
      slice_open = 1'b0;
      slice_id = '0;
      slice_proc = '0;
      foreach (proc_owner[i]) proc_owner[i] = '0;
    end else begin
      if (cmd_if.valid && cmd_if.ready) begin
        if (predict_dispatch(cmd_if.opcode, cmd_if.finished, pred)) expected_rsp.push_back(pred);
        accepted <= accepted + 1;
      end
      if (!cmd_if.valid || cmd_if.ready) begin
        if (send_gap > 0) begin
          send_gap--;
          cmd_if.valid <= 1'b0;
        end else if (cmd_pending.size() > 0) begin
          nxt = cmd_pending.pop_front();
          cmd_if.valid <= 1'b1;
          cmd_if.opcode <= nxt.op;
          cmd_if.finished <= nxt.fin;
          send_gap = pick_gap();
        end else begin
          cmd_if.valid <= 1'b0;
        end
      end
    end
  end

  // long response hold-off so the block backs up into its command side
  always @(posedge clk) begin : rsp_pressure
    if (rst) begin
      hold_rsp <= 1'b0;
      hold_cnt <= 0;
      next_pressure_at <= 250;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      hold_rsp <= (hold_cnt > 1);
    end else if (accepted >= next_pressure_at) begin
      hold_cnt <= PRESSURE_HOLD;
      hold_rsp <= 1'b1;
      next_pressure_at <= next_pressure_at + 600;
    end
  end

  // response monitor
  always @(posedge clk) begin : rsp_monitor
    rsp_beat_t want;
    string     diffs;
    if (rst) begin
      rsp_if.ready <= 1'b0;
      recv_gap = 0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        if (expected_rsp.size() == 0) begin
          log_mismatch($sformatf("result beat with nothing expected, status %0d id %0d",
                                 rsp_if.status, rsp_if.task_id));
        end else begin
          want = expected_rsp.pop_front();
          diffs = "";
          if (rsp_if.status !== want.status)
            diffs = {diffs, $sformatf(" status %0d/%0d", rsp_if.status, want.status)};
          if (rsp_if.task_id !== want.task_id)
            diffs = {diffs, $sformatf(" task_id %0d/%0d", rsp_if.task_id, want.task_id)};
          if (rsp_if.processor !== want.processor)
            diffs = {diffs, $sformatf(" processor %0d/%0d", rsp_if.processor, want.processor)};
          if (rsp_if.slice_budget !== want.slice_budget)
            diffs = {diffs, $sformatf(" budget %0d/%0d", rsp_if.slice_budget,
                                      want.slice_budget)};
          if (rsp_if.dispatched !== want.dispatched)
            diffs = {diffs, $sformatf(" dispatched %0d/%0d", rsp_if.dispatched,
                                      want.dispatched)};
          if (rsp_if.dispatched_id !== want.dispatched_id)
            diffs = {diffs, $sformatf(" dispatched_id %0d/%0d", rsp_if.dispatched_id,
                                      want.dispatched_id)};
          if (rsp_if.active !== want.active)
            diffs = {diffs, $sformatf(" active %0d/%0d", rsp_if.active, want.active)};
          if (diffs != "") log_mismatch({"got/expected:", diffs});
        end
      end
      if (hold_rsp) begin
        rsp_if.ready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= 1'b1;
        recv_gap = pick_gap();
      end
    end
  end

  always @(posedge clk) begin : watchdog
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_data = '0;
    slice_len = SLICE_RESET;
    queued_items = 0;
    no_idle = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed: empty queues, repeat grant, requeue, retire with and without dispatch
    add_item(OP_REPORT, 1'b0);
    add_item(OP_GRANT, 1'b1);
    add_item(OP_UNUSED, 1'b1);
    repeat (3) begin
      add_item(OP_SUBMIT, 1'b0);
      add_item(OP_SUBMIT, 1'b1);
    end
    add_item(OP_GRANT, 1'b0);
    add_item(OP_GRANT, 1'b0);
    add_item(OP_REPORT, 1'b0);
    add_item(OP_GRANT, 1'b0);
    add_item(OP_REPORT, 1'b1);
    add_item(OP_GRANT, 1'b0);
    add_item(OP_REPORT, 1'b1);
    add_item(OP_GRANT, 1'b0);
    add_item(OP_REPORT, 1'b1);
    add_item(OP_SUBMIT, 1'b0);
    add_item(OP_REPORT, 1'b1);
    wait_idle(8);

    write_slice(8'd0);
    add_random(100, 45, 20);
    wait_idle(8);

    write_slice(8'd255);
    no_idle = 1'b1;
    add_random(150, 12, 30);
    wait_idle(8);
    no_idle = 1'b0;

    write_slice(8'd1);
    add_random(450, 12, 30);
    wait_idle(8);

    write_slice(SLICE_W'($urandom_range(2, 254)));
    add_random(450, 10, 35);
    wait_idle(8);

    write_slice(SLICE_RESET);
    add_random(60, 8, 40);
    wait_idle(20);

    if (fail_count == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/mtd_pkg.sv
rtl/core/mtd_if.sv
rtl/core/mtd_ram.sv
rtl/core/mtd_ctrl.sv
rtl/core/mtd_datapath.sv
rtl/core/multiprocessor_task_dispatcher.sv
tb/tb_multiprocessor_task_dispatcher.sv
